// File: sv/wsfd_pkg.sv
`timescale 1ns / 1ps

package wsfd_pkg;

  localparam int unsigned LenW = 63;

  // The 7-bit length codes that announce an extended length
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  // Extended length byte counts
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [2:0] KeyBytes   = 3'd4;

  // Valid opcode range
  localparam logic [3:0] OpcodeMin = 4'd1;
  localparam logic [3:0] OpcodeMax = 4'd10;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [3:0]        ext_bytes_left;
    logic [LenW-1:0]   payload_length;
    logic [LenW-1:0]   bytes_received;
    logic [31:0]       mask_key;
    logic [2:0]        mask_bytes_left;
    logic              hdr_fin;
    logic [2:0]        hdr_rsv;
    logic [3:0]        hdr_opcode;
    logic              hdr_masked;
  } state_t;

  localparam state_t StateReset = '{
    phase:           PH_HDR0,
    ext_bytes_left:  '0,
    payload_length:  '0,
    bytes_received:  '0,
    mask_key:        '0,
    mask_bytes_left: '0,
    hdr_fin:         1'b0,
    hdr_rsv:         '0,
    hdr_opcode:      '0,
    hdr_masked:      1'b0
  };

  typedef struct packed {
    logic            consumed;
    logic [7:0]      out_byte;
    logic            out_valid;
    logic            frame_done;
    logic            bad_opcode;
    logic            fin_flag;
    logic [2:0]      rsv_bits;
    logic [3:0]      frame_opcode;
    logic            is_masked;
    logic [LenW-1:0] frame_length;
  } rsp_t;

endpackage

// File: sv/wsfd_in_if.sv
`timescale 1ns / 1ps

interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] in_byte;

  modport source (output valid, output mode, output in_byte, input ready);
  modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

// File: sv/wsfd_out_if.sv
`timescale 1ns / 1ps

interface wsfd_out_if
  import wsfd_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            consumed;
  logic [7:0]      out_byte;
  logic            out_valid;
  logic            frame_done;
  logic            bad_opcode;
  logic            fin_flag;
  logic [2:0]      rsv_bits;
  logic [3:0]      frame_opcode;
  logic            is_masked;
  logic [LenW-1:0] frame_length;

  modport source (output valid, output consumed, output out_byte, output out_valid,
                  output frame_done, output bad_opcode, output fin_flag,
                  output rsv_bits, output frame_opcode, output is_masked,
                  output frame_length, input ready);
  modport sink   (input valid, input consumed, input out_byte, input out_valid,
                  input frame_done, input bad_opcode, input fin_flag,
                  input rsv_bits, input frame_opcode, input is_masked,
                  input frame_length, output ready);
endinterface

// File: sv/wsfd_step.sv
`timescale 1ns / 1ps

module wsfd_step
  import wsfd_pkg::*;
(
  input  state_t     state_i,
  input  logic       mode_i,
  input  logic [7:0] in_byte_i,
  output state_t     state_o,
  output rsp_t       rsp_o
);

  logic [6:0]      len7;
  logic [7:0]      key_byte;
  logic [LenW-1:0] rcv_inc;
  logic            consumed;
  logic            bad;
  logic            ov;
  logic [7:0]      ob;
  state_t          nxt;

  assign len7    = in_byte_i[6:0];
  assign rcv_inc = state_i.bytes_received + LenW'(1);

  // key byte for payload position mod 4, first key byte in the top bits
  always_comb begin
    case (state_i.bytes_received[1:0])
      2'd0:    key_byte = state_i.mask_key[31:24];
      2'd1:    key_byte = state_i.mask_key[23:16];
      2'd2:    key_byte = state_i.mask_key[15:8];
      default: key_byte = state_i.mask_key[7:0];
    endcase
  end

  always_comb begin
    nxt      = state_i;
    consumed = 1'b0;
    bad      = 1'b0;
    ov       = 1'b0;
    ob       = '0;

    if (mode_i) begin
      nxt = StateReset;
    end else begin
      case (state_i.phase)
        PH_HDR0: begin
          consumed       = 1'b1;
          nxt.hdr_fin    = in_byte_i[7];
          nxt.hdr_rsv    = in_byte_i[6:4];
          nxt.hdr_opcode = in_byte_i[3:0];
          nxt.phase      = PH_HDR1;
        end
        PH_HDR1: begin
          consumed           = 1'b1;
          nxt.hdr_masked     = in_byte_i[7];
          nxt.payload_length = LenW'(len7);
          nxt.bytes_received = '0;
          if (!(state_i.hdr_opcode inside {[OpcodeMin:OpcodeMax]})) begin
            bad       = 1'b1;
            nxt.phase = PH_HDR0;
          end else if (len7 == Len7Ext16 || len7 == Len7Ext64) begin
            nxt.payload_length = '0;
            nxt.ext_bytes_left = (len7 == Len7Ext16) ? ExtBytes16 : ExtBytes64;
            nxt.phase          = PH_EXT;
          end else if (in_byte_i[7]) begin
            nxt.mask_bytes_left = KeyBytes;
            nxt.phase           = PH_MASK;
          end else begin
            nxt.phase = (len7 == 7'd0) ? PH_DONE : PH_PAYLOAD;
          end
        end
        PH_EXT: begin
          consumed           = 1'b1;
          nxt.payload_length = {state_i.payload_length[LenW-9:0], in_byte_i};
          nxt.ext_bytes_left = state_i.ext_bytes_left - 4'd1;
          if (nxt.ext_bytes_left == 4'd0) begin
            if (state_i.hdr_masked) begin
              nxt.mask_bytes_left = KeyBytes;
              nxt.phase           = PH_MASK;
            end else begin
              nxt.phase = (nxt.payload_length == '0) ? PH_DONE : PH_PAYLOAD;
            end
          end
        end
        PH_MASK: begin
          consumed            = 1'b1;
          nxt.mask_key        = {state_i.mask_key[23:0], in_byte_i};
          nxt.mask_bytes_left = state_i.mask_bytes_left - 3'd1;
          if (nxt.mask_bytes_left == 3'd0) begin
            nxt.phase = (state_i.payload_length == '0) ? PH_DONE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          consumed           = 1'b1;
          ov                 = 1'b1;
          ob                 = state_i.hdr_masked ? (in_byte_i ^ key_byte) : in_byte_i;
          nxt.bytes_received = rcv_inc;
          if (rcv_inc == state_i.payload_length) begin
            nxt.phase = PH_DONE;
          end
        end
        PH_DONE: begin
          // frame complete: refuse until restart
        end
        default: begin
          nxt.phase = PH_HDR0;
        end
      endcase
    end
  end

  assign state_o = nxt;

  assign rsp_o = '{
    consumed:     consumed,
    out_byte:     ob,
    out_valid:    ov,
    frame_done:   (nxt.phase == PH_DONE),
    bad_opcode:   bad,
    fin_flag:     nxt.hdr_fin,
    rsv_bits:     nxt.hdr_rsv,
    frame_opcode: nxt.hdr_opcode,
    is_masked:    nxt.hdr_masked,
    frame_length: nxt.payload_length
  };

endmodule

// File: sv/websocket_frame_deframer.sv
`timescale 1ns / 1ps

// Channel   Dir  Modport  Payload
// req_i     in   sink     mode, in_byte
// rsp_o     out  source   consumed, out_byte, out_valid, frame_done, bad_opcode,
//                         fin_flag, rsv_bits, frame_opcode, is_masked, frame_length
//
// One item per cycle unless stalled: each accepted item gives exactly one result
// item in the next cycle, held in the result register. The step is one state update
// plus one XOR; the longest path is the 63-bit received-count increment and compare.
// Reset (rst_ni low, async) clears the frame state to "waiting first header byte"
// and empties the result register.
// A new item is taken while a result sits in the register as long as that result
// is taken in the same cycle; only a stalled, full result register holds off req_i.

module websocket_frame_deframer
  import wsfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  wsfd_in_if.sink    req_i,
  wsfd_out_if.source rsp_o
);

  state_t state_q, state_d;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_vld_q;
  logic   in_fire;

  // Result register is free when empty or drained this cycle
  assign req_i.ready = !rsp_vld_q || rsp_o.ready;
  assign in_fire     = req_i.valid && req_i.ready;

  wsfd_step u_step (
    .state_i   (state_q),
    .mode_i    (req_i.mode),
    .in_byte_i (req_i.in_byte),
    .state_o   (state_d),
    .rsp_o     (rsp_d)
  );

  // Frame state advances only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateReset;
      rsp_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (req_i.ready) begin
        rsp_vld_q <= req_i.valid;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.consumed     = rsp_q.consumed;
  assign rsp_o.out_byte     = rsp_q.out_byte;
  assign rsp_o.out_valid    = rsp_q.out_valid;
  assign rsp_o.frame_done   = rsp_q.frame_done;
  assign rsp_o.bad_opcode   = rsp_q.bad_opcode;
  assign rsp_o.fin_flag     = rsp_q.fin_flag;
  assign rsp_o.rsv_bits     = rsp_q.rsv_bits;
  assign rsp_o.frame_opcode = rsp_q.frame_opcode;
  assign rsp_o.is_masked    = rsp_q.is_masked;
  assign rsp_o.frame_length = rsp_q.frame_length;

  // A restart item yields a cleared, unconsumed result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req_i.mode |=> rsp_o.valid && !rsp_o.consumed && rsp_o.frame_length == '0)
    else $error("restart result not cleared");

  // Done means every payload byte has been counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_DONE |-> state_q.bytes_received == state_q.payload_length)
    else $error("done with payload count short");

  // Extended length phase always has bytes still to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_EXT |-> state_q.ext_bytes_left != 4'd0)
    else $error("extended length count ran out");

  // A payload byte is always a consumed byte, and a bad header is never done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (!rsp_o.out_valid || rsp_o.consumed) &&
                    !(rsp_o.bad_opcode && rsp_o.frame_done))
    else $error("inconsistent result flags");

endmodule
